[design/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands shared by the checker files.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// prop must hold at every clock edge outside reset
`define ESM_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// cons must hold at the clock edge after ante
`define ESM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[design/esm_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esm_pkg
// Shared constants, register codes and compare helper of the stop matcher.
// ----------------------------------------------------------------------------
package esm_pkg;

	localparam int unsigned NUM_PATTERNS_DEF    = 3;
	localparam int unsigned MAX_PATTERN_LEN_DEF = 8;
	localparam int unsigned POSITION_WIDTH_DEF  = 16;

	localparam int unsigned PATTERN_SLOTS = 3;
	localparam int unsigned CFG_DATA_W    = 64;
	localparam int unsigned CFG_INDEX_W   = 3;
	localparam int unsigned BYTE_W        = 8;
	localparam int unsigned LEN_REG_W     = 4;
	localparam int unsigned CUT_W         = 16;
	localparam int unsigned PAT_IDX_W     = 2;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_PAT_A_BYTES  = 3'd0,
		REG_PAT_A_LEN    = 3'd1,
		REG_PAT_B_BYTES  = 3'd2,
		REG_PAT_B_LEN    = 3'd3,
		REG_PAT_C_BYTES  = 3'd4,
		REG_PAT_C_LEN    = 3'd5,
		REG_INCLUDE_STOP = 3'd6
	} cfg_reg_t;

	typedef struct packed {
		logic take;
		logic last;
	} esm_ctl_t;

	// true when window position pos does not break a match of pattern pat
	function automatic logic tap_ok(
		input logic [CFG_DATA_W-1:0] pat,
		input logic [LEN_REG_W-1:0]  len,
		input logic [LEN_REG_W-1:0]  pos,
		input logic [BYTE_W-1:0]     tap_byte,
		input logic                  tap_valid
	);
		logic [LEN_REG_W-1:0] diff;
		logic [2:0]           idx;
		diff = len - pos - 4'd1;
		idx  = diff[2:0];
		if (pos >= len) begin
			return 1'b1;
		end
		return tap_valid && (tap_byte == pat[{idx, 3'b000} +: BYTE_W]);
	endfunction

endpackage

[design/esm_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esm_in_if / esm_out_if
// Valid/ready channels for text beats and result beats.
// ----------------------------------------------------------------------------
interface esm_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] text_byte;
	logic       last_byte;

	modport source (output valid, output text_byte, output last_byte, input ready);
	modport sink   (input valid, input text_byte, input last_byte, output ready);
endinterface

interface esm_out_if;
	logic        valid;
	logic        ready;
	logic [15:0] cut_length;
	logic        stop_found;

	modport source (output valid, output cut_length, output stop_found, input ready);
	modport sink   (input valid, input cut_length, input stop_found, output ready);
endinterface

[design/esm_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esm_cell
// One window cell: holds a past text byte, shifts it on, compares it.
// ----------------------------------------------------------------------------
module esm_cell
	import esm_pkg::*;
#(
	parameter int unsigned NUM_PATTERNS = NUM_PATTERNS_DEF,
	parameter int unsigned TAP          = 1
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    shift,
	input  logic                    clear,
	input  logic [BYTE_W-1:0]       byte_in,
	input  logic                    valid_in,
	input  logic [CFG_DATA_W-1:0]   pat_bytes [PATTERN_SLOTS],
	input  logic [LEN_REG_W-1:0]    pat_len   [PATTERN_SLOTS],
	output logic [BYTE_W-1:0]       byte_out,
	output logic                    valid_out,
	output logic [NUM_PATTERNS-1:0] ok
);

	logic [BYTE_W-1:0] byte_q;
	logic              valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (shift) begin
			valid_q <= valid_in && !clear;
		end
	end

	always_ff @(posedge clk) begin
		if (shift) begin
			byte_q <= byte_in;
		end
	end

	always_comb begin
		for (int i = 0; i < NUM_PATTERNS; i++) begin
			ok[i] = tap_ok(pat_bytes[i], pat_len[i], LEN_REG_W'(TAP), byte_q, valid_q);
		end
	end

	assign byte_out  = byte_q;
	assign valid_out = valid_q;

endmodule

[design/esm_best.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esm_best
// Earliest-match tracker and result register.
// ----------------------------------------------------------------------------
module esm_best
	import esm_pkg::*;
#(
	parameter int unsigned NUM_PATTERNS   = NUM_PATTERNS_DEF,
	parameter int unsigned POSITION_WIDTH = POSITION_WIDTH_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  esm_ctl_t                  ctl,
	input  logic [NUM_PATTERNS-1:0]   match,
	input  logic [POSITION_WIDTH-1:0] start [NUM_PATTERNS],
	input  logic [LEN_REG_W-1:0]      len   [NUM_PATTERNS],
	input  logic [POSITION_WIDTH-1:0] text_len,
	input  logic                      include_stop,
	output logic                      out_free,
	esm_out_if.source                 result_out
);

	localparam int unsigned POS_W = POSITION_WIDTH;

	logic                 found_q;
	logic [POS_W-1:0]     best_start_q;
	logic [LEN_REG_W-1:0] best_len_q;
	logic [PAT_IDX_W-1:0] best_pat_q;
	logic                 out_valid_q;
	logic [CUT_W-1:0]     cut_q;
	logic                 stop_q;

	logic                 nx_found;
	logic [POS_W-1:0]     nx_start;
	logic [LEN_REG_W-1:0] nx_len;
	logic [PAT_IDX_W-1:0] nx_pat;
	logic [POS_W:0]       sum;
	logic [POS_W-1:0]     incl_cut;
	logic [POS_W-1:0]     cut_full;

	always_comb begin
		nx_found = found_q;
		nx_start = best_start_q;
		nx_len   = best_len_q;
		nx_pat   = best_pat_q;
		for (int i = 0; i < NUM_PATTERNS; i++) begin
			if (ctl.take && match[i] && (!nx_found || start[i] < nx_start ||
				(start[i] == nx_start && PAT_IDX_W'(i) < nx_pat))) begin
				nx_found = 1'b1;
				nx_start = start[i];
				nx_len   = len[i];
				nx_pat   = PAT_IDX_W'(i);
			end
		end
	end

	assign sum      = {1'b0, nx_start} + (POS_W + 1)'(nx_len);
	assign incl_cut = sum[POS_W] ? '1 : sum[POS_W-1:0];
	assign cut_full = nx_found ? (include_stop ? incl_cut : nx_start) : text_len;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q      <= 1'b0;
			best_start_q <= '0;
			best_len_q   <= '0;
			best_pat_q   <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (ctl.take) begin
				if (ctl.last) begin
					found_q      <= 1'b0;
					best_start_q <= '0;
					best_len_q   <= '0;
					best_pat_q   <= '0;
				end else begin
					found_q      <= nx_found;
					best_start_q <= nx_start;
					best_len_q   <= nx_len;
					best_pat_q   <= nx_pat;
				end
			end
			if (ctl.take && ctl.last) begin
				out_valid_q <= 1'b1;
			end else if (result_out.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.take && ctl.last) begin
			cut_q  <= CUT_W'(cut_full);
			stop_q <= nx_found;
		end
	end

	assign out_free              = !out_valid_q || result_out.ready;
	assign result_out.valid      = out_valid_q;
	assign result_out.cut_length = cut_q;
	assign result_out.stop_found = stop_q;

endmodule

[design/earliest_stop_string_match.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// earliest_stop_string_match
// Finds the earliest stop pattern in a byte stream and reports the cut length.
// ----------------------------------------------------------------------------
// Usage:
//   text_in takes one text beat (text_byte, last_byte) per cycle while ready is
//   high. Every beat is compared against up to three stop patterns by a row of
//   window cells; the beat flagged last_byte closes the text.
//   result_out gives one beat per text (cut_length, stop_found), registered in
//   the tracker after the last text beat has passed the stage-1 register.
//   Throughput is one text beat per cycle while text_in.ready is high, set by
//   the combinational window compare; the earliest-match tracker keeps pace.
//   Patterns and include_stop go through cfg_write/cfg_index/cfg_data; the user
//   must write them only while no text is in flight; it is not enforced.
//   Reset clears the patterns, the window, the position and the tracker.
//   While result_out stalls, text beats keep flowing until a second closed text
//   is waiting behind the held result; then text_in.ready drops.
// ----------------------------------------------------------------------------
module earliest_stop_string_match
	import esm_pkg::*;
#(
	parameter int unsigned NUM_PATTERNS    = NUM_PATTERNS_DEF,
	parameter int unsigned MAX_PATTERN_LEN = MAX_PATTERN_LEN_DEF,
	parameter int unsigned POSITION_WIDTH  = POSITION_WIDTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_write,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	esm_in_if.sink                 text_in,
	esm_out_if.source              result_out
);

	localparam int unsigned POS_W = POSITION_WIDTH;

	logic [CFG_DATA_W-1:0] pat_bytes_q [PATTERN_SLOTS];
	logic [LEN_REG_W-1:0]  pat_len_q   [PATTERN_SLOTS];
	logic                  incl_q;
	logic [LEN_REG_W-1:0]  len_eff     [PATTERN_SLOTS];

	logic [POS_W-1:0] pos_q;
	logic [POS_W:0]   seen;
	logic [POS_W-1:0] pos_next;
	logic             accept;
	logic             adv;
	logic             out_free;

	logic [BYTE_W-1:0]       win_byte  [MAX_PATTERN_LEN];
	logic                    win_valid [MAX_PATTERN_LEN];
	logic [NUM_PATTERNS-1:0] tap_hit   [MAX_PATTERN_LEN];
	logic [NUM_PATTERNS-1:0] hit;
	logic [POS_W-1:0]        start     [NUM_PATTERNS];

	logic                    v_s1;
	logic                    last_s1;
	logic [NUM_PATTERNS-1:0] match_s1;
	logic [POS_W-1:0]        start_s1  [NUM_PATTERNS];
	logic [LEN_REG_W-1:0]    len_s1    [NUM_PATTERNS];
	logic [POS_W-1:0]        tlen_s1;
	esm_ctl_t                ctl;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < PATTERN_SLOTS; i++) begin
				pat_bytes_q[i] <= '0;
				pat_len_q[i]   <= '0;
			end
			incl_q <= 1'b0;
		end else if (cfg_write) begin
			case (cfg_reg_t'(cfg_index))
				REG_PAT_A_BYTES:  pat_bytes_q[0] <= cfg_data;
				REG_PAT_A_LEN:    pat_len_q[0]   <= cfg_data[LEN_REG_W-1:0];
				REG_PAT_B_BYTES:  pat_bytes_q[1] <= cfg_data;
				REG_PAT_B_LEN:    pat_len_q[1]   <= cfg_data[LEN_REG_W-1:0];
				REG_PAT_C_BYTES:  pat_bytes_q[2] <= cfg_data;
				REG_PAT_C_LEN:    pat_len_q[2]   <= cfg_data[LEN_REG_W-1:0];
				REG_INCLUDE_STOP: incl_q         <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// overlong lengths act as the longest supported pattern
	always_comb begin
		for (int i = 0; i < PATTERN_SLOTS; i++) begin
			len_eff[i] = (pat_len_q[i] > LEN_REG_W'(MAX_PATTERN_LEN)) ?
				LEN_REG_W'(MAX_PATTERN_LEN) : pat_len_q[i];
		end
	end

	assign accept   = text_in.valid && text_in.ready;
	assign seen     = {1'b0, pos_q} + (POS_W + 1)'(1);
	assign pos_next = seen[POS_W] ? '1 : seen[POS_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (accept) begin
			pos_q <= text_in.last_byte ? '0 : pos_next;
		end
	end

	// tap 0 is the incoming byte, taps above it live in the cells
	assign win_byte[0]  = text_in.text_byte;
	assign win_valid[0] = 1'b1;

	always_comb begin
		for (int i = 0; i < NUM_PATTERNS; i++) begin
			tap_hit[0][i] = tap_ok(pat_bytes_q[i], len_eff[i], '0, win_byte[0], 1'b1);
		end
	end

	for (genvar k = 1; k < MAX_PATTERN_LEN; k++) begin : g_cell
		esm_cell #(
			.NUM_PATTERNS(NUM_PATTERNS),
			.TAP         (k)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.shift    (accept),
			.clear    (text_in.last_byte),
			.byte_in  (win_byte[k-1]),
			.valid_in (win_valid[k-1]),
			.pat_bytes(pat_bytes_q),
			.pat_len  (len_eff),
			.byte_out (win_byte[k]),
			.valid_out(win_valid[k]),
			.ok       (tap_hit[k])
		);
	end

	always_comb begin
		for (int i = 0; i < NUM_PATTERNS; i++) begin
			hit[i] = (len_eff[i] != '0);
			for (int k = 0; k < MAX_PATTERN_LEN; k++) begin
				hit[i] = hit[i] && tap_hit[k][i];
			end
			start[i] = POS_W'(seen - (POS_W + 1)'(len_eff[i]));
		end
	end

	assign adv           = !v_s1 || !last_s1 || out_free;
	assign text_in.ready = adv;
	assign ctl.take      = v_s1 && adv;
	assign ctl.last      = last_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= text_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			last_s1  <= text_in.last_byte;
			match_s1 <= hit;
			tlen_s1  <= pos_next;
			for (int i = 0; i < NUM_PATTERNS; i++) begin
				start_s1[i] <= start[i];
				len_s1[i]   <= len_eff[i];
			end
		end
	end

	esm_best #(
		.NUM_PATTERNS  (NUM_PATTERNS),
		.POSITION_WIDTH(POSITION_WIDTH)
	) u_best (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (ctl),
		.match       (match_s1),
		.start       (start_s1),
		.len         (len_s1),
		.text_len    (tlen_s1),
		.include_stop(incl_q),
		.out_free    (out_free),
		.result_out  (result_out)
	);

endmodule

[design/esm_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esm_checker
// Port-level checks of the stop matcher, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module esm_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        in_last,
	input logic        out_valid,
	input logic        out_ready,
	input logic [15:0] cut_length,
	input logic        stop_found
);

	// closed texts whose result beat is not yet taken
	logic [1:0] pending_q;
	logic       last_in;
	logic       out_beat;

	assign last_in  = in_valid && in_ready && in_last;
	assign out_beat = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else if (last_in && !out_beat) begin
			pending_q <= pending_q + 2'd1;
		end else if (out_beat && !last_in) begin
			pending_q <= pending_q - 2'd1;
		end
	end

	`ESM_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready,
		out_valid && $stable(cut_length) && $stable(stop_found), "result beat dropped or changed")
	`ESM_ASSERT(a_no_spurious, clk, arst_n, !out_valid || pending_q != 2'd0,
		"result beat without a closed text")
	`ESM_ASSERT(a_depth, clk, arst_n, pending_q <= 2'd2, "too many closed texts in flight")
	`ESM_ASSERT(a_ready_idle, clk, arst_n, pending_q != 2'd0 || in_ready,
		"text input stalled with nothing in flight")

endmodule

bind earliest_stop_string_match esm_checker u_esm_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (text_in.valid),
	.in_ready  (text_in.ready),
	.in_last   (text_in.last_byte),
	.out_valid (result_out.valid),
	.out_ready (result_out.ready),
	.cut_length(result_out.cut_length),
	.stop_found(result_out.stop_found)
);

[tb/earliest_stop_string_match_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// earliest_stop_string_match_test
// Self-checking bench for the stop matcher: a short directed script, then
// random pattern sets with texts built from pattern copies and noise. Every
// result beat is compared against a script value or an earliest-match predictor.
// ----------------------------------------------------------------------------
module earliest_stop_string_match_test;
	import esm_pkg::*;

	typedef struct packed {
		logic [CUT_W-1:0] cut;
		logic             found;
	} cut_beat_t;

	typedef struct packed {
		logic [BYTE_W-1:0] text;
		logic              last;
		logic              typed;
		logic [CUT_W-1:0]  cut;
		logic              found;
	} script_row_t;

	localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 3'd7;
	localparam int unsigned POS_LIMIT     = 65535;
	localparam int unsigned HIST_DEPTH    = 8;
	localparam int unsigned RANDOM_PHASES = 12;
	localparam int unsigned PHASE_BEATS   = 100;
	localparam int unsigned HOLD_PHASE    = 3;
	localparam int unsigned STEADY_PHASE  = 5;
	localparam int unsigned HOLD_CYCLES   = 400;
	localparam int unsigned TAIL_CYCLES   = 10;
	localparam int unsigned SCRIPT_ROWS   = 17;

	localparam cfg_reg_t BYTES_REG [PATTERN_SLOTS] = '{
		REG_PAT_A_BYTES, REG_PAT_B_BYTES, REG_PAT_C_BYTES
	};
	localparam cfg_reg_t LEN_REG [PATTERN_SLOTS] = '{
		REG_PAT_A_LEN, REG_PAT_B_LEN, REG_PAT_C_LEN
	};

	// patterns: A = "abc", B = "bc", C = 00 FF 00 FF 11 22 33 44 with length 15
	localparam script_row_t SCRIPT [SCRIPT_ROWS] = '{
		'{8'h78, 1'b1, 1'b1, 16'd1, 1'b0},
		'{8'h61, 1'b0, 1'b0, 16'd0, 1'b0},
		'{8'h62, 1'b0, 1'b0, 16'd0, 1'b0},
		'{8'h63, 1'b1, 1'b1, 16'd0, 1'b1},
		'{8'h63, 1'b1, 1'b1, 16'd1, 1'b0},
		'{8'h7A, 1'b0, 1'b0, 16'd0, 1'b0},
		'{8'h62, 1'b0, 1'b0, 16'd0, 1'b0},
		'{8'h63, 1'b1, 1'b0, 16'd0, 1'b0},
		'{8'h00, 1'b0, 1'b0, 16'd0, 1'b0},
		'{8'hFF, 1'b0, 1'b0, 16'd0, 1'b0},
		'{8'h00, 1'b0, 1'b0, 16'd0, 1'b0},
		'{8'hFF, 1'b0, 1'b0, 16'd0, 1'b0},
		'{8'h11, 1'b0, 1'b0, 16'd0, 1'b0},
		'{8'h22, 1'b0, 1'b0, 16'd0, 1'b0},
		'{8'h33, 1'b0, 1'b0, 16'd0, 1'b0},
		'{8'h44, 1'b1, 1'b1, 16'd0, 1'b1},
		'{8'hFF, 1'b1, 1'b1, 16'd1, 1'b0}
	};

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_write;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;

	esm_in_if  text_in ();
	esm_out_if result_out ();

	earliest_stop_string_match dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_write  (cfg_write),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.text_in    (text_in),
		.result_out (result_out)
	);

	logic [CFG_DATA_W-1:0] stop_bytes [PATTERN_SLOTS];
	logic [LEN_REG_W-1:0]  stop_len [PATTERN_SLOTS];
	logic                  keep_stop;
	logic [BYTE_W-1:0]     recent [HIST_DEPTH-1];
	int unsigned           text_pos;
	int unsigned           best_start;
	int unsigned           best_len;
	int unsigned           best_slot;
	bit                    have_match;

	cut_beat_t         pending_cuts [$];
	logic [BYTE_W-1:0] alphabet [$];

	int unsigned errors = 0;
	int unsigned beats_sent = 0;
	int unsigned texts_closed = 0;
	int unsigned cuts_checked = 0;
	int unsigned cuts_with_stop = 0;
	bit          send_gaps = 1'b1;
	bit          recv_gaps = 1'b1;
	int unsigned hold_request = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("earliest_stop_string_match test failed");
		$finish;
	end

	function automatic int unsigned clamp_pos(input int unsigned v);
		return (v > POS_LIMIT) ? POS_LIMIT : v;
	endfunction

	function automatic int unsigned live_len(input int unsigned slot);
		return (stop_len[slot] > MAX_PATTERN_LEN_DEF) ? MAX_PATTERN_LEN_DEF : stop_len[slot];
	endfunction

	function automatic void clear_text();
		foreach (recent[i]) recent[i] = '0;
		text_pos   = 0;
		best_start = 0;
		best_len   = 0;
		best_slot  = 0;
		have_match = 1'b0;
	endfunction

	// one text beat through the tracker; returns 1 with the cut on the last beat
	function automatic bit advance_matcher(input logic [BYTE_W-1:0] b, input logic l,
			output cut_beat_t res);
		logic [BYTE_W-1:0] hist [HIST_DEPTH];
		int unsigned seen, len, start, slot, k;
		bit hit;
		res = '0;
		hist[0] = b;
		for (k = 1; k < HIST_DEPTH; k++) hist[k] = recent[k-1];
		seen = text_pos + 1;
		for (slot = 0; slot < NUM_PATTERNS_DEF; slot++) begin
			len = live_len(slot);
			hit = (len != 0) && (seen >= len);
			for (k = 0; k < len; k++)
				if (hist[k] != stop_bytes[slot][BYTE_W*(len-1-k) +: BYTE_W]) hit = 1'b0;
			start = clamp_pos(seen - len);
			if (hit && (!have_match || start < best_start ||
					(start == best_start && slot < best_slot))) begin
				have_match = 1'b1;
				best_start = start;
				best_len   = len;
				best_slot  = slot;
			end
		end
		for (k = HIST_DEPTH - 2; k > 0; k--) recent[k] = recent[k-1];
		recent[0] = b;
		text_pos = clamp_pos(seen);
		if (!l)
			return 1'b0;
		res.found = have_match;
		if (have_match)
			res.cut = CUT_W'(keep_stop ? clamp_pos(best_start + best_len) : best_start);
		else
			res.cut = CUT_W'(clamp_pos(seen));
		clear_text();
		return 1'b1;
	endfunction

	task automatic report_mismatch(input string what, input cut_beat_t got,
			input cut_beat_t want);
		$display("MISMATCH %0t: %s: cut %0d stop %0b, wanted cut %0d stop %0b",
			$time, what, got.cut, got.found, want.cut, want.found);
		errors++;
	endtask

	// called at a falling edge; leaves cfg_write high for the next write
	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] val);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		case (idx)
			REG_PAT_A_BYTES:  stop_bytes[0] = val;
			REG_PAT_A_LEN:    stop_len[0]   = val[LEN_REG_W-1:0];
			REG_PAT_B_BYTES:  stop_bytes[1] = val;
			REG_PAT_B_LEN:    stop_len[1]   = val[LEN_REG_W-1:0];
			REG_PAT_C_BYTES:  stop_bytes[2] = val;
			REG_PAT_C_LEN:    stop_len[2]   = val[LEN_REG_W-1:0];
			REG_INCLUDE_STOP: keep_stop     = val[0];
			default: ;
		endcase
		@(negedge clk);
	endtask

	task automatic end_writes();
		cfg_write <= 1'b0;
	endtask

	// called at a falling edge, returns at the falling edge after the beat is taken
	task automatic feed_beat(input logic [BYTE_W-1:0] b, input logic l,
			input logic typed, input cut_beat_t typed_res);
		cut_beat_t res;
		while (send_gaps && $urandom_range(99) < 9) begin
			text_in.valid <= 1'b0;
			@(negedge clk);
		end
		text_in.valid     <= 1'b1;
		text_in.text_byte <= b;
		text_in.last_byte <= l;
		@(posedge clk);
		while (!text_in.ready) @(posedge clk);
		beats_sent++;
		if (advance_matcher(b, l, res)) begin
			pending_cuts.insert(pending_cuts.size(), typed ? typed_res : res);
			texts_closed++;
		end
		@(negedge clk);
	endtask

	// text of n beats: whole pattern copies, broken copies, alphabet bytes and noise
	task automatic send_text(input int unsigned n);
		logic [BYTE_W-1:0] txt [$];
		int unsigned slot, k, cnt, r;
		while (txt.size() < n) begin
			r    = $urandom_range(99);
			slot = $urandom_range(PATTERN_SLOTS - 1);
			cnt  = live_len(slot);
			if (r < 40 && cnt != 0) begin
				if (r >= 30) cnt = $urandom_range(cnt, 1);
				for (k = 0; k < cnt; k++)
					txt.insert(txt.size(), stop_bytes[slot][BYTE_W*k +: BYTE_W]);
			end else if (r < 80) begin
				txt.insert(txt.size(), alphabet[$urandom_range(alphabet.size() - 1)]);
			end else begin
				txt.insert(txt.size(), BYTE_W'($urandom));
			end
		end
		while (txt.size() > n) void'(txt.pop_back());
		for (k = 0; k < n; k++) feed_beat(txt[k], k == n - 1, 1'b0, '0);
	endtask

	task automatic random_config(input int unsigned ph);
		logic [CFG_DATA_W-1:0] v;
		int unsigned slot, k, r;
		alphabet.delete();
		r = $urandom_range(4, 2);
		for (k = 0; k < r; k++) alphabet.insert(alphabet.size(), BYTE_W'($urandom));
		for (slot = 0; slot < PATTERN_SLOTS; slot++) begin
			v = {$urandom, $urandom};
			if ($urandom_range(99) < 70)
				for (k = 0; k < MAX_PATTERN_LEN_DEF; k++)
					v[BYTE_W*k +: BYTE_W] = alphabet[$urandom_range(alphabet.size() - 1)];
			write_reg(BYTES_REG[slot], v);
			v = ($urandom_range(99) < 50) ? {$urandom, $urandom} : '0;
			r = $urandom_range(99);
			if (ph == 0)
				v[LEN_REG_W-1:0] = '0;
			else if (ph == 1)
				v[LEN_REG_W-1:0] = LEN_REG_W'(MAX_PATTERN_LEN_DEF);
			else if (ph == 2)
				v[LEN_REG_W-1:0] = '1;
			else if (r < 10)
				v[LEN_REG_W-1:0] = '0;
			else if (r < 20)
				v[LEN_REG_W-1:0] = LEN_REG_W'($urandom_range(15, 9));
			else if (r < 35)
				v[LEN_REG_W-1:0] = LEN_REG_W'(MAX_PATTERN_LEN_DEF);
			else
				v[LEN_REG_W-1:0] = LEN_REG_W'($urandom_range(7, 1));
			write_reg(LEN_REG[slot], v);
		end
		v = ($urandom_range(99) < 50) ? {$urandom, $urandom} : '0;
		v[0] = 1'($urandom_range(1));
		write_reg(REG_INCLUDE_STOP, v);
		write_reg(REG_UNUSED, {$urandom, $urandom});
		end_writes();
	endtask

	task automatic drain();
		text_in.valid <= 1'b0;
		while (pending_cuts.size() != 0) @(negedge clk);
		repeat (TAIL_CYCLES) @(negedge clk);
	endtask

	initial begin
		int unsigned hold_left;
		hold_left = 0;
		result_out.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request != 0) begin
				hold_left    = hold_request;
				hold_request = 0;
			end
			if (hold_left != 0) begin
				result_out.ready <= 1'b0;
				hold_left--;
			end else begin
				result_out.ready <= !(recv_gaps && $urandom_range(99) < 9);
			end
		end
	end

	always @(posedge clk) begin : check_cut
		cut_beat_t got;
		cut_beat_t want;
		if (arst_n && result_out.valid && result_out.ready) begin
			got.cut   = result_out.cut_length;
			got.found = result_out.stop_found;
			cuts_checked++;
			if (got.found) cuts_with_stop++;
			if (pending_cuts.size() == 0) begin
				report_mismatch("result beat with nothing pending", got, '0);
			end else begin
				want = pending_cuts.pop_front();
				if (got.cut !== want.cut || got.found !== want.found)
					report_mismatch("result beat", got, want);
			end
		end
	end

	initial begin
		cut_beat_t typed_res;
		int unsigned ph, row, goal;
		arst_n            = 1'b0;
		cfg_write         = 1'b0;
		cfg_index         = '0;
		cfg_data          = '0;
		text_in.valid     = 1'b0;
		text_in.text_byte = '0;
		text_in.last_byte = 1'b0;
		foreach (stop_bytes[i]) begin
			stop_bytes[i] = '0;
			stop_len[i]   = '0;
		end
		keep_stop = 1'b0;
		clear_text();
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		write_reg(REG_PAT_A_BYTES, 64'h5A5A_5A5A_5A63_6261);
		write_reg(REG_PAT_A_LEN, 64'd3);
		write_reg(REG_PAT_B_BYTES, 64'hA5A5_A5A5_A5A5_6362);
		write_reg(REG_PAT_B_LEN, 64'd2);
		write_reg(REG_PAT_C_BYTES, 64'h4433_2211_FF00_FF00);
		write_reg(REG_PAT_C_LEN, 64'hF);
		write_reg(REG_INCLUDE_STOP, 64'd0);
		write_reg(REG_UNUSED, '1);
		end_writes();
		for (row = 0; row < SCRIPT_ROWS; row++) begin
			typed_res.cut   = SCRIPT[row].cut;
			typed_res.found = SCRIPT[row].found;
			feed_beat(SCRIPT[row].text, SCRIPT[row].last, SCRIPT[row].typed, typed_res);
		end
		drain();

		for (ph = 0; ph < RANDOM_PHASES; ph++) begin
			random_config(ph);
			send_gaps = (ph != STEADY_PHASE);
			recv_gaps = (ph != STEADY_PHASE);
			if (ph == HOLD_PHASE) hold_request = HOLD_CYCLES;
			goal = beats_sent + PHASE_BEATS;
			while (beats_sent < goal)
				send_text(($urandom_range(99) < 85) ? $urandom_range(12, 1) : $urandom_range(40, 13));
			drain();
		end

		$display("Sent %0d text beats in %0d texts over %0d random pattern sets",
			beats_sent, texts_closed, RANDOM_PHASES);
		$display("Checked %0d result beats, %0d with a stop found, %0d mismatches",
			cuts_checked, cuts_with_stop, errors);
		if (errors == 0)
			$display("earliest_stop_string_match test passed");
		else
			$display("earliest_stop_string_match test failed");
		$finish;
	end

endmodule

[earliest_stop_string_match.f]
+incdir+design
design/esm_pkg.sv
design/esm_if.sv
design/esm_cell.sv
design/esm_best.sv
design/earliest_stop_string_match.sv
design/esm_checker.sv
tb/earliest_stop_string_match_test.sv
